@@ hdl/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

    // sizes of the matrices and elements
    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 32;

    // fixed field widths of the ports
    localparam int OP_W   = 2;
    localparam int POS_W  = 3;
    localparam int DIM_W  = 4;
    localparam int VAL_W  = 32;
    localparam int CFG_IDX_W = 2;

    // derived widths
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PROD_W    = 2 * ELEM_WIDTH;
    localparam int ACC_RAW_W = PROD_W + IDX_W + 1;
    localparam int ACC_W     = (ACC_RAW_W > VAL_W + 1) ? ACC_RAW_W : VAL_W + 1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // operation codes of an input transaction
    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

    // classified command kinds
    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_COMPUTE,
        CMD_MISMATCH
    } t_kind;

    // one command passed from front to back
    typedef struct packed {
        t_kind                         kind;
        logic [IDX_W-1:0]              row;
        logic [IDX_W-1:0]              col;
        logic signed [ELEM_WIDTH-1:0]  value;
        logic [IDX_W-1:0]              last_i;
        logic [IDX_W-1:0]              last_j;
        logic [IDX_W-1:0]              last_k;
    } t_cmd;

    // tag riding along the multiply pipeline
    typedef struct packed {
        logic             valid;
        logic             err;
        logic             first_k;
        logic             last_k;
        logic             last_el;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage

@@ hdl/imm_front.sv @@
// ----------------------------------------------------------------------------
// imm_front
// Holds the dimension registers and classifies input transactions into
// commands for the back end.
// ----------------------------------------------------------------------------
module imm_front import imm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DIM_W-1:0]      i_cfg_data,
    input  logic                  i_push,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [POS_W-1:0]      i_row_index,
    input  logic [POS_W-1:0]      i_col_index,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_cmd                  o_q_cmd
);

    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_cols_a;
    logic [DIM_W-1:0] r_rows_b;
    logic [DIM_W-1:0] r_cols_b;

    logic [IDX_W-1:0] last_ra;
    logic [IDX_W-1:0] last_ca;
    logic [IDX_W-1:0] last_rb;
    logic [IDX_W-1:0] last_cb;
    logic             in_range;
    logic             accept;

    // clamp a dimension to 1..MAX_DIM and return its last index
    function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] c;
        if (v == '0) begin
            c = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            c = DIM_W'(MAX_DIM);
        end else begin
            c = v;
        end
        return IDX_W'(c - DIM_W'(1));
    endfunction

    // dimension registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= DIM_W'(1);
            r_cols_a <= DIM_W'(1);
            r_rows_b <= DIM_W'(1);
            r_cols_b <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROWS_A: r_rows_a <= i_cfg_data;
                REG_COLS_A: r_cols_a <= i_cfg_data;
                REG_ROWS_B: r_rows_b <= i_cfg_data;
                REG_COLS_B: r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign last_ra  = last_index(r_rows_a);
    assign last_ca  = last_index(r_cols_a);
    assign last_rb  = last_index(r_rows_b);
    assign last_cb  = last_index(r_cols_b);
    assign in_range = (int'(i_row_index) < MAX_DIM) && (int'(i_col_index) < MAX_DIM);
    assign accept   = i_push && !i_q_full;

    // classify the transaction
    always_comb begin
        o_q_cmd.row    = IDX_W'(i_row_index);
        o_q_cmd.col    = IDX_W'(i_col_index);
        o_q_cmd.value  = ELEM_WIDTH'(i_element_value);
        o_q_cmd.last_i = last_ra;
        o_q_cmd.last_j = last_cb;
        o_q_cmd.last_k = last_ca;
        o_q_cmd.kind   = CMD_COMPUTE;
        o_q_push       = 1'b0;
        case (i_operation)
            OP_LOAD_A: begin
                o_q_cmd.kind = CMD_LOAD_A;
                o_q_push     = accept && in_range;
            end
            OP_LOAD_B: begin
                o_q_cmd.kind = CMD_LOAD_B;
                o_q_push     = accept && in_range;
            end
            OP_COMPUTE: begin
                o_q_cmd.kind = (last_ca != last_rb) ? CMD_MISMATCH : CMD_COMPUTE;
                o_q_push     = accept;
            end
            default: o_q_push = 1'b0;
        endcase
    end

endmodule

@@ hdl/imm_queue.sv @@
// ----------------------------------------------------------------------------
// imm_queue
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module imm_queue import imm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/imm_back.sv @@
// ----------------------------------------------------------------------------
// imm_back
// Element stores, product sequencer and multiply-accumulate pipeline with
// the result register.
// ----------------------------------------------------------------------------
module imm_back import imm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic                    i_cmd_empty,
    output logic                    o_cmd_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic [POS_W-1:0]        o_out_row,
    output logic [POS_W-1:0]        o_out_col,
    output logic signed [VAL_W-1:0] o_product_value,
    output logic                    o_overflowed,
    output logic                    o_status,
    output logic                    o_last
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // element stores
    logic signed [ELEM_WIDTH-1:0] r_mem_a [MEM_DEPTH];
    logic signed [ELEM_WIDTH-1:0] r_mem_b [MEM_DEPTH];
    logic signed [ELEM_WIDTH-1:0] r_rd_a;
    logic signed [ELEM_WIDTH-1:0] r_rd_b;

    // sequencer
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_last_i, n_last_i;
    logic [IDX_W-1:0] r_last_j, n_last_j;
    logic [IDX_W-1:0] r_last_k, n_last_k;

    // pipeline
    t_tag                     issue;
    t_tag                     r_s1, r_s2, r_s3;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;

    // result register
    logic                     r_out_valid;
    logic [POS_W-1:0]         r_out_row;
    logic [POS_W-1:0]         r_out_col;
    logic signed [VAL_W-1:0]  r_out_value;
    logic                     r_out_ovf;
    logic                     r_out_status;
    logic                     r_out_last;

    logic                     adv;
    logic                     take;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        addr_b;
    logic [ADDR_W-1:0]        waddr;
    logic                     we_a;
    logic                     we_b;

    // whole pipeline moves while the result slot is free or being emptied
    assign adv       = !r_out_valid || i_pop;
    assign take      = adv && (r_state == ST_IDLE) && !i_cmd_empty;
    assign o_cmd_pop = take;
    assign waddr     = {i_cmd.row, i_cmd.col};
    assign we_a      = take && (i_cmd.kind == CMD_LOAD_A);
    assign we_b      = take && (i_cmd.kind == CMD_LOAD_B);
    assign addr_a    = {r_i, r_k};
    assign addr_b    = {r_k, r_j};

    // issue tag and next sequencer state
    always_comb begin
        issue    = '0;
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_last_i = r_last_i;
        n_last_j = r_last_j;
        n_last_k = r_last_k;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    case (i_cmd.kind)
                        CMD_COMPUTE: begin
                            n_state  = ST_RUN;
                            n_i      = '0;
                            n_j      = '0;
                            n_k      = '0;
                            n_last_i = i_cmd.last_i;
                            n_last_j = i_cmd.last_j;
                            n_last_k = i_cmd.last_k;
                        end
                        CMD_MISMATCH: begin
                            issue.valid   = 1'b1;
                            issue.err     = 1'b1;
                            issue.first_k = 1'b1;
                            issue.last_k  = 1'b1;
                            issue.last_el = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                issue.valid   = 1'b1;
                issue.first_k = (r_k == '0);
                issue.last_k  = (r_k == r_last_k);
                issue.last_el = (r_i == r_last_i) && (r_j == r_last_j);
                issue.row     = r_i;
                issue.col     = r_j;
                if (adv) begin
                    if (r_k != r_last_k) begin
                        n_k = r_k + IDX_W'(1);
                    end else begin
                        n_k = '0;
                        if (r_j != r_last_j) begin
                            n_j = r_j + IDX_W'(1);
                        end else begin
                            n_j = '0;
                            if (r_i != r_last_i) begin
                                n_i = r_i + IDX_W'(1);
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_last_i <= '0;
            r_last_j <= '0;
            r_last_k <= '0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_last_i <= n_last_i;
            r_last_j <= n_last_j;
            r_last_k <= n_last_k;
        end
    end

    // store of matrix a
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[waddr] <= i_cmd.value;
        end
        if (adv) begin
            r_rd_a <= r_mem_a[addr_a];
        end
    end

    // store of matrix b
    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[waddr] <= i_cmd.value;
        end
        if (adv) begin
            r_rd_b <= r_mem_b[addr_b];
        end
    end

    // pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (adv) begin
            r_s1 <= issue;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    assign prod_ext = ACC_W'(r_prod);

    // multiply, then accumulate at full width
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= r_rd_a * r_rd_b;
            if (r_s2.valid) begin
                r_acc <= r_s2.first_k ? prod_ext : r_acc + prod_ext;
            end
        end
    end

    // result register handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s3.valid && r_s3.last_k;
        end
    end

    // saturate and load the result payload
    always_ff @(posedge i_clk) begin
        if (adv && r_s3.valid && r_s3.last_k) begin
            r_out_row    <= POS_W'(r_s3.row);
            r_out_col    <= POS_W'(r_s3.col);
            r_out_status <= r_s3.err;
            r_out_last   <= r_s3.last_el;
            if (r_s3.err) begin
                r_out_value <= '0;
                r_out_ovf   <= 1'b0;
            end else if (r_acc > SAT_HI) begin
                r_out_value <= VAL_W'(SAT_HI);
                r_out_ovf   <= 1'b1;
            end else if (r_acc < SAT_LO) begin
                r_out_value <= VAL_W'(SAT_LO);
                r_out_ovf   <= 1'b1;
            end else begin
                r_out_value <= VAL_W'(r_acc);
                r_out_ovf   <= 1'b0;
            end
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_value;
    assign o_overflowed    = r_out_ovf;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

endmodule

@@ hdl/integer_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Signed integer matrix multiplier for matrices of up to 8 by 8 elements.
//
// Input side is a queue: a transaction is taken when push is high and
// full is low. Operation 0 and 1 load one element of A or B, operation 2
// asks for the product, operation 3 is dropped. Transactions pass through a
// four-entry command queue to the back end.
// Result side is a queue: the oldest result sits on the o_ ports while
// empty is low and is taken when pop is high.
// A compute emits rows_of_a * cols_of_b results in row-major order, o_last on
// the final one; a dimension mismatch gives one result with o_status high.
// The back end reads one A and one B element per cycle, while the result
// register is free or being emptied, through a single multiplier, and takes
// no new command until a compute has issued all rows_of_a * cols_of_b *
// cols_of_a of its products.
// When the receiver stalls, the result register holds and the whole back end
// pipeline freezes; the command queue keeps taking transactions until full.
// Dimension registers are written through i_cfg_we and reset to 1. Reset
// clears the control state only; element stores hold nothing until loaded.
// ----------------------------------------------------------------------------
module integer_matrix_multiply import imm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [DIM_W-1:0]        i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [POS_W-1:0]        i_row_index,
    input  logic [POS_W-1:0]        i_col_index,
    input  logic signed [VAL_W-1:0] i_element_value,
    output logic                    empty,
    input  logic                    pop,
    output logic [POS_W-1:0]        o_out_row,
    output logic [POS_W-1:0]        o_out_col,
    output logic signed [VAL_W-1:0] o_product_value,
    output logic                    o_overflowed,
    output logic                    o_status,
    output logic                    o_last
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_out;

    assign full = q_full;

    // classification and dimension registers
    imm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .i_operation     (i_operation),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_cmd         (q_in)
    );

    // command queue
    imm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    // stores, sequencer and multiply-accumulate
    imm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (q_out),
        .i_cmd_empty     (q_empty),
        .o_cmd_pop       (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_overflowed    (o_overflowed),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule
